// ----- hw/rtl/rc_failsafe_tank_mixer_top_assert.svh -----
// ----------------------------------------------------------------------------
// rc_failsafe_tank_mixer_top_assert.svh
// Assertion macros for the tank mixer; empty when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef RC_FAILSAFE_TANK_MIXER_TOP_ASSERT_SVH
`define RC_FAILSAFE_TANK_MIXER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// cond must hold in every cycle out of reset
`define RCFTM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);
// cons must hold in the same cycle as ante
`define RCFTM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// cons must hold in the cycle after ante
`define RCFTM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RCFTM_ASSERT_ALWAYS(lbl, cond, msg)
`define RCFTM_ASSERT_IMPL(lbl, ante, cons, msg)
`define RCFTM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/rcftm_pkg.sv -----
// ----------------------------------------------------------------------------
// rcftm_pkg
// Shared types, codes and reset values for the RC failsafe tank mixer.
// ----------------------------------------------------------------------------
package rcftm_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int NOW_W          = 32;
    localparam int APB_AW         = 5;
    localparam int APB_DW         = 32;

    // event opcodes
    localparam logic [1:0] OP_STEER    = 2'd0;
    localparam logic [1:0] OP_THROTTLE = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    // link status codes
    localparam logic [1:0] LINK_LOST  = 2'd0;
    localparam logic [1:0] LINK_GOOD  = 2'd1;
    localparam logic [1:0] LINK_STALE = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_MIN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_MAX_WIDTH  = 3'd1;
    localparam logic [2:0] REG_FRESH_TO   = 3'd2;
    localparam logic [2:0] REG_BAD_LIMIT  = 3'd3;
    localparam logic [2:0] REG_CENTER     = 3'd4;
    localparam logic [2:0] REG_DEADBAND   = 3'd5;

    // reset values
    localparam logic [15:0] RST_MIN_WIDTH = 16'd1000;
    localparam logic [15:0] RST_MAX_WIDTH = 16'd2000;
    localparam logic [31:0] RST_FRESH_TO  = 32'd1000000;
    localparam logic [7:0]  RST_BAD_LIMIT = 8'd10;
    localparam logic [15:0] RST_CENTER    = 16'd1500;
    localparam logic [15:0] RST_DEADBAND  = 16'd100;

    localparam logic [7:0]  BAD_SAT       = 8'd255;

    typedef struct packed {
        logic [15:0] min_width;
        logic [15:0] max_width;
        logic [31:0] fresh_timeout;
        logic [7:0]  bad_limit;
        logic [15:0] center;
        logic [15:0] deadband;
    } t_cfg;

    typedef struct packed {
        logic [7:0] left_fwd;
        logic [7:0] left_rev;
        logic [7:0] right_fwd;
        logic [7:0] right_rev;
    } t_duties;

endpackage

// ----- hw/rtl/rcftm_cfg.sv -----
// ----------------------------------------------------------------------------
// rcftm_cfg
// APB register bank holding the thresholds and mixer settings.
// ----------------------------------------------------------------------------
module rcftm_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcftm_pkg::APB_AW-1:0]  paddr,
    input  logic [rcftm_pkg::APB_DW-1:0]  pwdata,
    output logic [rcftm_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    output rcftm_pkg::t_cfg               o_cfg
);
    import rcftm_pkg::*;

    logic [15:0] r_min_width;
    logic [15:0] r_max_width;
    logic [31:0] r_fresh_to;
    logic [7:0]  r_bad_limit;
    logic [15:0] r_center;
    logic [15:0] r_deadband;
    logic [2:0]  w_index;
    logic        w_wr;

    assign pready  = 1'b1;
    assign w_index = paddr[APB_AW-1:2];
    assign w_wr    = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_width <= RST_MIN_WIDTH;
            r_max_width <= RST_MAX_WIDTH;
            r_fresh_to  <= RST_FRESH_TO;
            r_bad_limit <= RST_BAD_LIMIT;
            r_center    <= RST_CENTER;
            r_deadband  <= RST_DEADBAND;
        end else if (w_wr) begin
            case (w_index)
                REG_MIN_WIDTH: r_min_width <= pwdata[15:0];
                REG_MAX_WIDTH: r_max_width <= pwdata[15:0];
                REG_FRESH_TO:  r_fresh_to  <= pwdata[31:0];
                REG_BAD_LIMIT: r_bad_limit <= pwdata[7:0];
                REG_CENTER:    r_center    <= pwdata[15:0];
                REG_DEADBAND:  r_deadband  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            REG_MIN_WIDTH: prdata = APB_DW'(r_min_width);
            REG_MAX_WIDTH: prdata = APB_DW'(r_max_width);
            REG_FRESH_TO:  prdata = APB_DW'(r_fresh_to);
            REG_BAD_LIMIT: prdata = APB_DW'(r_bad_limit);
            REG_CENTER:    prdata = APB_DW'(r_center);
            REG_DEADBAND:  prdata = APB_DW'(r_deadband);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.min_width     = r_min_width;
    assign o_cfg.max_width     = r_max_width;
    assign o_cfg.fresh_timeout = r_fresh_to;
    assign o_cfg.bad_limit     = r_bad_limit;
    assign o_cfg.center        = r_center;
    assign o_cfg.deadband      = r_deadband;

endmodule

// ----- hw/rtl/rcftm_capture.sv -----
// ----------------------------------------------------------------------------
// rcftm_capture
// Pulse decoder: start time on a rising edge, width on a falling edge.
// ----------------------------------------------------------------------------
module rcftm_capture #(
    parameter int TIME_WIDTH = rcftm_pkg::TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [1:0]            i_op,
    input  logic                  i_level,
    input  logic [TIME_WIDTH-1:0] i_now,
    output logic [TIME_WIDTH-1:0] o_steer_start,
    output logic [TIME_WIDTH-1:0] o_steer_width,
    output logic [TIME_WIDTH-1:0] o_thr_start,
    output logic [TIME_WIDTH-1:0] o_thr_width
);
    import rcftm_pkg::*;

    logic [TIME_WIDTH-1:0] r_steer_start;
    logic [TIME_WIDTH-1:0] r_steer_width;
    logic [TIME_WIDTH-1:0] r_thr_start;
    logic [TIME_WIDTH-1:0] r_thr_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer_start <= '0;
            r_steer_width <= '0;
            r_thr_start   <= '0;
            r_thr_width   <= '0;
        end else if (i_fire) begin
            case (i_op)
                OP_STEER: begin
                    if (i_level) r_steer_start <= i_now;
                    else         r_steer_width <= i_now - r_steer_start;
                end
                OP_THROTTLE: begin
                    if (i_level) r_thr_start <= i_now;
                    else         r_thr_width <= i_now - r_thr_start;
                end
                default: ;
            endcase
        end
    end

    assign o_steer_start = r_steer_start;
    assign o_steer_width = r_steer_width;
    assign o_thr_start   = r_thr_start;
    assign o_thr_width   = r_thr_width;

endmodule

// ----- hw/rtl/rcftm_mixer.sv -----
// ----------------------------------------------------------------------------
// rcftm_mixer
// Deadband, percent scaling and tank mix of steering and throttle widths.
// ----------------------------------------------------------------------------
module rcftm_mixer (
    input  rcftm_pkg::t_cfg    i_cfg,
    input  logic [15:0]        i_steer_width,
    input  logic [15:0]        i_thr_width,
    output rcftm_pkg::t_duties o_duties
);
    import rcftm_pkg::*;

    // x / 5 == (x * 52429) >> 18, exact for 16-bit x
    localparam logic [31:0] DIV5_RECIP = 32'd52429;
    localparam int          DIV5_SHIFT = 18;

    function automatic logic signed [14:0] f_percent(
        input logic [15:0] w,
        input logic [15:0] c,
        input logic [15:0] d
    );
        logic signed [17:0] v;
        logic signed [17:0] lo;
        logic signed [17:0] hi;
        logic signed [16:0] diff;
        logic [15:0]        mag;
        logic [31:0]        prod;
        logic [13:0]        q;
        v    = $signed({2'b00, w});
        lo   = $signed({2'b00, c}) - $signed({2'b00, d});
        hi   = $signed({2'b00, c}) + $signed({2'b00, d});
        diff = $signed({1'b0, w}) - $signed({1'b0, c});
        mag  = diff[16] ? 16'(-diff) : diff[15:0];
        prod = {16'd0, mag} * DIV5_RECIP;
        q    = prod[DIV5_SHIFT+13:DIV5_SHIFT];
        if (v > hi || v < lo) begin
            // truncate toward zero: divide the magnitude, restore the sign
            f_percent = diff[16] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end else begin
            f_percent = '0;
        end
    endfunction

    // clamp to +/-100 and split into {fwd, rev} duties
    function automatic logic [15:0] f_split(input logic signed [15:0] p);
        logic signed [7:0] c;
        logic [7:0]        m;
        logic [7:0]        fwd;
        logic [7:0]        rev;
        if (p > 16'sd100)       c = 8'sd100;
        else if (p < -16'sd100) c = -8'sd100;
        else                    c = p[7:0];
        m   = 8'(-c);
        fwd = (c > 8'sd0) ? {c[6:0], 1'b0} : 8'd0;
        rev = (c < 8'sd0) ? {m[6:0], 1'b0} : 8'd0;
        f_split = {fwd, rev};
    endfunction

    logic signed [14:0] w_t;
    logic signed [14:0] w_s;
    logic signed [15:0] w_t16;
    logic signed [15:0] w_s16;
    logic signed [15:0] w_left;
    logic signed [15:0] w_right;
    logic [15:0]        w_left_split;
    logic [15:0]        w_right_split;

    always_comb begin
        w_t   = f_percent(i_thr_width, i_cfg.center, i_cfg.deadband);
        w_s   = f_percent(i_steer_width, i_cfg.center, i_cfg.deadband);
        w_t16 = 16'(w_t);
        w_s16 = 16'(w_s);
        // reversing swaps the steering sense
        if (!w_t16[15]) begin
            w_left  = w_t16 + w_s16;
            w_right = w_t16 - w_s16;
        end else begin
            w_left  = w_t16 - w_s16;
            w_right = w_t16 + w_s16;
        end
        w_left_split  = f_split(w_left);
        w_right_split = f_split(w_right);
    end

    assign o_duties.left_fwd  = w_left_split[15:8];
    assign o_duties.left_rev  = w_left_split[7:0];
    assign o_duties.right_fwd = w_right_split[15:8];
    assign o_duties.right_rev = w_right_split[7:0];

endmodule

// ----- hw/rtl/rc_failsafe_tank_mixer_top.sv -----
// ----------------------------------------------------------------------------
// rc_failsafe_tank_mixer_top
// RC pulse decoder and tank-drive mixer with link failsafe.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// in        to block   i_in_valid / o_in_stall   i_opcode, i_level, i_now_us
// out       from block o_out_valid / i_out_stall duties, link status, flags
// cfg       to block   APB psel/penable/pready   paddr, pwdata, prdata
//
// One item per cycle: input register, one pass of compare, scale and mix
// logic, result register. A tick result is registered when the tick leaves
// the input register. An edge leaves the input register at the next edge; the
// input stalls only while a tick waits on a full, stalled result register.
// Synchronous active-low reset, no clearing pass.
// ----------------------------------------------------------------------------
`include "rc_failsafe_tank_mixer_top_assert.svh"

module rc_failsafe_tank_mixer_top #(
    parameter int TIME_WIDTH = rcftm_pkg::TIME_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic                          i_level,
    input  logic [rcftm_pkg::NOW_W-1:0]   i_now_us,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_duty_left_fwd,
    output logic [7:0]                    o_duty_left_rev,
    output logic [7:0]                    o_duty_right_fwd,
    output logic [7:0]                    o_duty_right_rev,
    output logic [1:0]                    o_link_status,
    output logic [7:0]                    o_bad_ticks,
    output logic                          o_steer_valid,
    output logic                          o_steer_fresh,
    output logic                          o_throttle_valid,
    output logic                          o_throttle_fresh,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcftm_pkg::APB_AW-1:0]  paddr,
    input  logic [rcftm_pkg::APB_DW-1:0]  pwdata,
    output logic [rcftm_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import rcftm_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > NOW_W) ? TIME_WIDTH : NOW_W;

    t_cfg                  w_cfg;
    t_duties               w_mix;

    logic                  r_in_valid;
    logic [1:0]            r_in_op;
    logic                  r_in_level;
    logic [NOW_W-1:0]      r_in_now;

    logic                  r_out_valid;
    t_duties               r_out_duties;
    logic [1:0]            r_out_link;
    logic [7:0]            r_out_bad;
    logic                  r_out_sv;
    logic                  r_out_sf;
    logic                  r_out_tv;
    logic                  r_out_tf;

    t_duties               r_held;
    t_duties               n_held;
    logic [7:0]            r_bad;
    logic [7:0]            n_bad;
    logic [1:0]            n_link;

    logic [TIME_WIDTH-1:0] w_now;
    logic [TIME_WIDTH-1:0] w_steer_start;
    logic [TIME_WIDTH-1:0] w_steer_width;
    logic [TIME_WIDTH-1:0] w_thr_start;
    logic [TIME_WIDTH-1:0] w_thr_width;
    logic [TIME_WIDTH-1:0] w_steer_age;
    logic [TIME_WIDTH-1:0] w_thr_age;

    logic                  w_is_tick;
    logic                  w_adv;
    logic                  w_tick_go;
    logic                  w_accept;
    logic                  w_sv;
    logic                  w_sf;
    logic                  w_tv;
    logic                  w_tf;
    logic                  w_lost;

    rcftm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ---- handshake ----
    assign w_is_tick  = (r_in_op == OP_TICK);
    assign w_adv      = r_in_valid && (!w_is_tick || !r_out_valid || !i_out_stall);
    assign w_tick_go  = w_adv && w_is_tick;
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_op    <= i_opcode;
            r_in_level <= i_level;
            r_in_now   <= i_now_us;
        end
    end

    assign w_now = TIME_WIDTH'(r_in_now);

    rcftm_capture #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_capture (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_adv),
        .i_op          (r_in_op),
        .i_level       (r_in_level),
        .i_now         (w_now),
        .o_steer_start (w_steer_start),
        .o_steer_width (w_steer_width),
        .o_thr_start   (w_thr_start),
        .o_thr_width   (w_thr_width)
    );

    // ---- link health ----
    assign w_steer_age = w_now - w_steer_start;
    assign w_thr_age   = w_now - w_thr_start;

    assign w_sv = (CMP_W'(w_steer_width) >= CMP_W'(w_cfg.min_width))
               && (CMP_W'(w_steer_width) <= CMP_W'(w_cfg.max_width));
    assign w_tv = (CMP_W'(w_thr_width) >= CMP_W'(w_cfg.min_width))
               && (CMP_W'(w_thr_width) <= CMP_W'(w_cfg.max_width));
    assign w_sf = CMP_W'(w_steer_age) <= CMP_W'(w_cfg.fresh_timeout);
    assign w_tf = CMP_W'(w_thr_age) <= CMP_W'(w_cfg.fresh_timeout);

    // widths are only mixed when valid, so they fit in 16 bits then
    rcftm_mixer u_mixer (
        .i_cfg         (w_cfg),
        .i_steer_width (w_steer_width[15:0]),
        .i_thr_width   (w_thr_width[15:0]),
        .o_duties      (w_mix)
    );

    always_comb begin
        if (w_sv && w_tv && w_sf && w_tf) n_bad = '0;
        else if (r_bad != BAD_SAT)        n_bad = r_bad + 8'd1;
        else                              n_bad = r_bad;

        w_lost = !(w_sf && w_tf) || (n_bad > w_cfg.bad_limit);

        if (w_lost) begin
            n_link = LINK_LOST;
            n_held = '0;
        end else if (w_sv && w_tv) begin
            n_link = LINK_GOOD;
            n_held = w_mix;
        end else begin
            n_link = LINK_STALE;
            n_held = r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad  <= '0;
            r_held <= '0;
        end else if (w_tick_go) begin
            r_bad  <= n_bad;
            r_held <= n_held;
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tick_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick_go) begin
            r_out_duties <= n_held;
            r_out_link   <= n_link;
            r_out_bad    <= n_bad;
            r_out_sv     <= w_sv;
            r_out_sf     <= w_sf;
            r_out_tv     <= w_tv;
            r_out_tf     <= w_tf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_duty_left_fwd  = r_out_duties.left_fwd;
    assign o_duty_left_rev  = r_out_duties.left_rev;
    assign o_duty_right_fwd = r_out_duties.right_fwd;
    assign o_duty_right_rev = r_out_duties.right_rev;
    assign o_link_status    = r_out_link;
    assign o_bad_ticks      = r_out_bad;
    assign o_steer_valid    = r_out_sv;
    assign o_steer_fresh    = r_out_sf;
    assign o_throttle_valid = r_out_tv;
    assign o_throttle_fresh = r_out_tf;

    // ---- assertions ----
    `RCFTM_ASSERT_IMPL(a_lost_zero, r_out_valid && (r_out_link == LINK_LOST), r_out_duties == '0, "lost link with non-zero duty")
    `RCFTM_ASSERT_IMPL(a_good_clears, r_out_valid && (r_out_link == LINK_GOOD), r_out_bad == '0, "good link with bad ticks")
    `RCFTM_ASSERT_NEXT(a_stale_holds, w_tick_go && (n_link == LINK_STALE), r_held == $past(r_held), "stale tick changed held duties")
    `RCFTM_ASSERT_IMPL(a_stall_cause, o_in_stall, r_in_valid && w_is_tick && r_out_valid && i_out_stall, "input stalled without a blocked tick")

endmodule

// ----- bench/rc_failsafe_tank_mixer_top_tb.sv -----
// ----------------------------------------------------------------------------
// rc_failsafe_tank_mixer_top_tb
// Self-checking bench for the RC failsafe tank mixer. Steering and throttle
// edges and control ticks go in over the valid/stall channel. A predictor in
// the bench decodes the pulses, tracks the bad tick count and the held duties,
// and works out every tick result. It runs a short stimulus table, then random
// pulse frames under several register settings written over APB.
// ----------------------------------------------------------------------------
module rc_failsafe_tank_mixer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcftm_pkg::*;

    localparam int         CLK_PERIOD      = 10;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         DRAIN_CYCLES    = 8;
    localparam int         NUM_PHASES      = 4;
    localparam int         ITEMS_PER_PHASE = 400;
    localparam int         HOLD_CYCLES     = 300;
    localparam logic [1:0] OP_UNUSED       = 2'd3;

    typedef struct packed {
        logic [7:0] lf;
        logic [7:0] lr;
        logic [7:0] rf;
        logic [7:0] rr;
        logic [1:0] link;
        logic [7:0] bad;
        logic       steer_ok;
        logic       steer_live;
        logic       thr_ok;
        logic       thr_live;
    } mix_result_t;

    typedef struct {
        logic [1:0]  op;
        logic        lvl;
        logic [31:0] now;
        bit          typed;
        mix_result_t res;
    } stim_row_t;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_opcode    = OP_STEER;
    logic                 i_level     = 1'b0;
    logic [NOW_W-1:0]     i_now_us    = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [7:0]           o_duty_left_fwd;
    logic [7:0]           o_duty_left_rev;
    logic [7:0]           o_duty_right_fwd;
    logic [7:0]           o_duty_right_rev;
    logic [1:0]           o_link_status;
    logic [7:0]           o_bad_ticks;
    logic                 o_steer_valid;
    logic                 o_steer_fresh;
    logic                 o_throttle_valid;
    logic                 o_throttle_fresh;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [APB_AW-1:0]    paddr       = '0;
    logic [APB_DW-1:0]    pwdata      = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // predictor state
    t_cfg        mix_cfg = '{RST_MIN_WIDTH, RST_MAX_WIDTH, RST_FRESH_TO, RST_BAD_LIMIT,
                             RST_CENTER, RST_DEADBAND};
    logic [31:0] steer_rise_us  = '0;
    logic [31:0] steer_pulse_us = '0;
    logic [31:0] thr_rise_us    = '0;
    logic [31:0] thr_pulse_us   = '0;
    logic [7:0]  bad_run        = '0;
    t_duties     held           = '0;

    mix_result_t tick_results_q[$];
    stim_row_t   directed_rows[$];
    mix_result_t got_res;
    mix_result_t want_res;

    logic [31:0] sim_us         = '0;
    bit          no_idle        = 1'b0;
    bit          hold_req       = 1'b0;
    bit          hold_done      = 1'b0;
    int          hold_left      = 0;
    int          cycle_count    = 0;
    int          mismatches     = 0;
    int          items_in       = 0;
    int          phase_items    = 0;
    int          directed_count = 0;
    int          results_seen   = 0;
    int          n_good         = 0;
    int          n_stale        = 0;
    int          n_lost         = 0;

    rc_failsafe_tank_mixer_top DUT (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // stick position in percent, zero inside the deadband
    function automatic longint stick_percent(input logic [31:0] w);
        longint v, c, d;
        v = longint'(w);
        c = longint'(mix_cfg.center);
        d = longint'(mix_cfg.deadband);
        if (v > c + d || v < c - d)
            return (v - c) / 5;
        return 0;
    endfunction

    function automatic void side_duty(input longint p, output logic [7:0] fwd,
                                      output logic [7:0] rev);
        longint q;
        q = (p > 100) ? 100 : ((p < -100) ? -100 : p);
        fwd = (q > 0) ? 8'(2 * q) : 8'd0;
        rev = (q < 0) ? 8'(-2 * q) : 8'd0;
    endfunction

    // returns 1 when the item is a tick, with its result in r
    function automatic bit advance_mixer(input logic [1:0] op, input logic lvl,
                                         input logic [31:0] now, output mix_result_t r);
        logic [31:0] s_age, t_age;
        longint      tp, sp, lside, rside;
        r = '0;
        if (op == OP_STEER) begin
            if (lvl) steer_rise_us = now;
            else steer_pulse_us = now - steer_rise_us;
            return 1'b0;
        end
        if (op == OP_THROTTLE) begin
            if (lvl) thr_rise_us = now;
            else thr_pulse_us = now - thr_rise_us;
            return 1'b0;
        end
        if (op != OP_TICK)
            return 1'b0;

        s_age = now - steer_rise_us;
        t_age = now - thr_rise_us;
        r.steer_ok   = steer_pulse_us >= mix_cfg.min_width && steer_pulse_us <= mix_cfg.max_width;
        r.thr_ok     = thr_pulse_us >= mix_cfg.min_width && thr_pulse_us <= mix_cfg.max_width;
        r.steer_live = s_age <= mix_cfg.fresh_timeout;
        r.thr_live   = t_age <= mix_cfg.fresh_timeout;

        if (r.steer_ok && r.thr_ok && r.steer_live && r.thr_live)
            bad_run = '0;
        else if (bad_run != BAD_SAT)
            bad_run = bad_run + 8'd1;

        if (!(r.steer_live && r.thr_live) || bad_run > mix_cfg.bad_limit) begin
            held = '0;
            r.link = LINK_LOST;
            n_lost++;
        end else if (r.steer_ok && r.thr_ok) begin
            tp = stick_percent(thr_pulse_us);
            sp = stick_percent(steer_pulse_us);
            // reversing swaps the steering sense
            if (tp >= 0) begin
                lside = tp + sp;
                rside = tp - sp;
            end else begin
                lside = tp - sp;
                rside = tp + sp;
            end
            side_duty(lside, held.left_fwd, held.left_rev);
            side_duty(rside, held.right_fwd, held.right_rev);
            r.link = LINK_GOOD;
            n_good++;
        end else begin
            r.link = LINK_STALE;
            n_stale++;
        end
        r.lf  = held.left_fwd;
        r.lr  = held.left_rev;
        r.rf  = held.right_fwd;
        r.rr  = held.right_rev;
        r.bad = bad_run;
        return 1'b1;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic lvl, input logic [31:0] now,
                           input bit typed = 1'b0, input mix_result_t res = '0);
        stim_row_t r;
        r.op    = op;
        r.lvl   = lvl;
        r.now   = now;
        r.typed = typed;
        r.res   = res;
        directed_rows.push_back(r);
    endtask

    // offer one item and hold it until accepted
    task automatic drive_item(input logic [1:0] op, input logic lvl, input logic [31:0] now,
                              input bit typed = 1'b0, input mix_result_t typed_res = '0);
        mix_result_t pred;
        if (!no_idle && $urandom_range(99) < 20) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_level    <= lvl;
        i_now_us   <= now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (advance_mixer(op, lvl, now, pred))
            tick_results_q.push_back(typed ? typed_res : pred);
        items_in++;
        if (op != OP_UNUSED)
            phase_items++;
    endtask

    task automatic send_pulse(input logic [1:0] ch, input logic [31:0] w);
        drive_item(ch, 1'b1, sim_us);
        sim_us += w;
        drive_item(ch, 1'b0, sim_us);
        sim_us += 32'($urandom_range(0, 3000));
    endtask

    function automatic logic [31:0] pick_width();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55 && mix_cfg.min_width <= mix_cfg.max_width)
            return 32'($urandom_range(mix_cfg.max_width, mix_cfg.min_width));
        if (sel < 70) begin
            case ($urandom_range(3))
                0: return 32'(mix_cfg.min_width) - 32'd1;
                1: return 32'(mix_cfg.min_width);
                2: return 32'(mix_cfg.max_width);
                default: return 32'(mix_cfg.max_width) + 32'd1;
            endcase
        end
        // deadband edges, either side
        if (sel < 85) begin
            if ($urandom_range(1))
                return 32'(mix_cfg.center) + 32'(mix_cfg.deadband) + 32'($urandom_range(1));
            return 32'(mix_cfg.center) - 32'(mix_cfg.deadband) - 32'($urandom_range(1));
        end
        if (sel < 93)
            return 32'($urandom_range(65535));
        return $urandom;
    endfunction

    task automatic random_frame();
        int          kind;
        bit          steer_first;
        logic [31:0] burst_w;
        kind = $urandom_range(99);
        if (kind < 65) begin
            steer_first = 1'($urandom_range(1));
            if ($urandom_range(9) < 8)
                send_pulse(steer_first ? OP_STEER : OP_THROTTLE, pick_width());
            if ($urandom_range(9) < 8)
                send_pulse(steer_first ? OP_THROTTLE : OP_STEER, pick_width());
            repeat ($urandom_range(1, 3)) begin
                drive_item(OP_TICK, 1'($urandom_range(1)), sim_us);
                sim_us += 32'($urandom_range(0, 2000));
            end
        end else if (kind < 80) begin
            // a bad steering pulse, then a run of ticks towards the bad limit
            burst_w = $urandom_range(1) ? 32'(mix_cfg.max_width) + 32'd1
                                        : 32'(mix_cfg.min_width) - 32'd1;
            send_pulse(OP_STEER, burst_w);
            repeat ($urandom_range(3, 15)) begin
                drive_item(OP_TICK, 1'($urandom_range(1)), sim_us);
                sim_us += 32'($urandom_range(0, 500));
            end
        end else if (kind < 88) begin
            // right on the freshness edge, or one past it
            sim_us = ($urandom_range(1) ? steer_rise_us : thr_rise_us)
                   + mix_cfg.fresh_timeout + 32'($urandom_range(1));
            drive_item(OP_TICK, 1'($urandom_range(1)), sim_us);
        end else begin
            drive_item(2'($urandom_range(3)), 1'($urandom_range(1)), $urandom);
        end
    endtask

    // write a register, then read it back
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cmp_field("prdata", val, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MIN_WIDTH: mix_cfg.min_width     = val[15:0];
            REG_MAX_WIDTH: mix_cfg.max_width     = val[15:0];
            REG_FRESH_TO:  mix_cfg.fresh_timeout = val;
            REG_BAD_LIMIT: mix_cfg.bad_limit     = val[7:0];
            REG_CENTER:    mix_cfg.center        = val[15:0];
            REG_DEADBAND:  mix_cfg.deadband      = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // block may still hold an edge item after the last result
    task automatic wait_idle();
        while (tick_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req && !hold_done) begin
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(99) < 20);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_res = '{o_duty_left_fwd, o_duty_left_rev, o_duty_right_fwd, o_duty_right_rev,
                        o_link_status, o_bad_ticks, o_steer_valid, o_steer_fresh,
                        o_throttle_valid, o_throttle_fresh};
            if (tick_results_q.size() == 0) begin
                $error("result item with nothing expected");
                mismatches++;
            end else begin
                want_res = tick_results_q.pop_front();
                results_seen++;
                cmp_field("duty_left_fwd", 32'(want_res.lf), 32'(got_res.lf));
                cmp_field("duty_left_rev", 32'(want_res.lr), 32'(got_res.lr));
                cmp_field("duty_right_fwd", 32'(want_res.rf), 32'(got_res.rf));
                cmp_field("duty_right_rev", 32'(want_res.rr), 32'(got_res.rr));
                cmp_field("link_status", 32'(want_res.link), 32'(got_res.link));
                cmp_field("bad_ticks", 32'(want_res.bad), 32'(got_res.bad));
                cmp_field("steer_valid", 32'(want_res.steer_ok), 32'(got_res.steer_ok));
                cmp_field("steer_fresh", 32'(want_res.steer_live), 32'(got_res.steer_live));
                cmp_field("throttle_valid", 32'(want_res.thr_ok), 32'(got_res.thr_ok));
                cmp_field("throttle_fresh", 32'(want_res.thr_live), 32'(got_res.thr_live));
            end
        end
    end

    initial begin
        t_cfg phase_cfg [NUM_PHASES];
        t_cfg next;

        // wide open, then empty window with zero timeout, then a typical
        // receiver setup, then a random one
        phase_cfg[0] = '{16'd0, 16'd65535, 32'hFFFF_FFFF, 8'd255, 16'd0, 16'd0};
        phase_cfg[1] = '{16'd65535, 16'd0, 32'd0, 8'd0, 16'd65535, 16'd65535};
        phase_cfg[2] = '{16'd900, 16'd2100, 32'd20000, 8'd3, 16'd1500, 16'd20};
        phase_cfg[3] = '{16'($urandom_range(500, 1500)), 16'($urandom_range(1500, 2500)),
                         32'($urandom_range(3000, 2000000)), 8'($urandom_range(0, 20)),
                         16'($urandom_range(1200, 1800)), 16'($urandom_range(0, 300))};

        // first tick after reset: no widths yet but both starts at zero
        add_row(OP_TICK, 1'b0, 32'd0, 1'b1,
                mix_result_t'{8'd0, 8'd0, 8'd0, 8'd0, LINK_STALE, 8'd1,
                              1'b0, 1'b1, 1'b0, 1'b1});
        add_row(OP_TICK, 1'b1, 32'hFFFF_FFFF, 1'b1,
                mix_result_t'{8'd0, 8'd0, 8'd0, 8'd0, LINK_LOST, 8'd2,
                              1'b0, 1'b0, 1'b0, 1'b0});
        add_row(OP_UNUSED, 1'b1, 32'hFFFF_FFFF);
        add_row(OP_UNUSED, 1'b0, 32'd0);
        add_row(OP_STEER, 1'b1, 32'd100);
        add_row(OP_STEER, 1'b0, 32'd1600);
        add_row(OP_THROTTLE, 1'b1, 32'd200);
        add_row(OP_THROTTLE, 1'b0, 32'd2200);
        // full throttle, steering centred
        add_row(OP_TICK, 1'b1, 32'd3000, 1'b1,
                mix_result_t'{8'd200, 8'd0, 8'd200, 8'd0, LINK_GOOD, 8'd0,
                              1'b1, 1'b1, 1'b1, 1'b1});
        // full reverse with hard steering, one side clamps
        add_row(OP_THROTTLE, 1'b1, 32'd4000);
        add_row(OP_THROTTLE, 1'b0, 32'd5000);
        add_row(OP_STEER, 1'b1, 32'd4000);
        add_row(OP_STEER, 1'b0, 32'd5999);
        add_row(OP_TICK, 1'b0, 32'd6000);
        // one past the deadband
        add_row(OP_STEER, 1'b1, 32'd7000);
        add_row(OP_STEER, 1'b0, 32'd8601);
        add_row(OP_TICK, 1'b0, 32'd9000);
        // pulses across the timestamp wrap, negative steering truncates
        add_row(OP_STEER, 1'b1, 32'hFFFF_FF00);
        add_row(OP_STEER, 1'b0, 32'h0000_0300);
        add_row(OP_THROTTLE, 1'b1, 32'hFFFF_FF80);
        add_row(OP_THROTTLE, 1'b0, 32'h0000_0500);
        add_row(OP_TICK, 1'b0, 32'h0000_0600);
        // throttle one over max: duties held
        add_row(OP_THROTTLE, 1'b0, 32'h0000_0751);
        add_row(OP_TICK, 1'b0, 32'h0000_0800);
        // steering age exactly at the timeout, then one past it
        add_row(OP_TICK, 1'b0, 32'h000F_4140);
        add_row(OP_TICK, 1'b0, 32'h000F_4141);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            drive_item(directed_rows[k].op, directed_rows[k].lvl, directed_rows[k].now,
                       directed_rows[k].typed, directed_rows[k].res);
        i_in_valid <= 1'b0;
        directed_count = items_in;
        sim_us = $urandom;

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            next = phase_cfg[p];
            reg_write(REG_MIN_WIDTH, 32'(next.min_width));
            reg_write(REG_MAX_WIDTH, 32'(next.max_width));
            reg_write(REG_FRESH_TO, next.fresh_timeout);
            reg_write(REG_BAD_LIMIT, 32'(next.bad_limit));
            reg_write(REG_CENTER, 32'(next.center));
            reg_write(REG_DEADBAND, 32'(next.deadband));
            no_idle <= (p == 2);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                // long output hold-off mid phase so the input backs up
                if (p == 2 && phase_items > 100 && !hold_req)
                    hold_req <= 1'b1;
                random_frame();
            end
            i_in_valid <= 1'b0;
        end
        wait_idle();

        $display("Sent %0d input items (%0d from the table) under %0d register settings.",
                 items_in, directed_count, NUM_PHASES + 1);
        $display("Checked %0d tick results: %0d driving, %0d holding, %0d stopped.",
                 results_seen, n_good, n_stale, n_lost);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
